### sv/tos_pkg.sv
// Shared types and constants for the thrust overflow scaler.
package tos_pkg;

  localparam int unsigned NumLanes            = 8;
  localparam int unsigned ThrustW             = 16;
  localparam int unsigned MagW                = ThrustW + 1;
  localparam int unsigned LimitW              = 15;
  localparam int unsigned FractionBitsDefault = 16;

  localparam logic [LimitW-1:0] LimitReset = 15'd32767;

  typedef logic signed [ThrustW-1:0] thrust_t;
  typedef logic [MagW-1:0]           mag_t;

  // Sign and magnitude of every command in one set.
  typedef struct packed {
    logic [NumLanes-1:0] neg;
    mag_t [NumLanes-1:0] mag;
  } cmd_t;

endpackage

### sv/tos_peak.sv
// Per-lane magnitude and a registered max tree that finds the peak and the overflow flag.
module tos_peak import tos_pkg::*; (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  thrust_t [NumLanes-1:0]    thrust_i,
  input  logic    [LimitW-1:0]      limit_i,
  output cmd_t                      cmd_o,
  output mag_t                      peak_o,
  output logic                      ovf_o
);

  function automatic mag_t mag_max(input mag_t a, input mag_t b);
    return (a > b) ? a : b;
  endfunction

  cmd_t       cmd_d, cmd_q;
  mag_t [1:0] pair_d, pair_q;
  mag_t       peak_d, peak_q;
  logic       ovf_d, ovf_q;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      cmd_d.neg[i] = thrust_i[i][ThrustW-1];
      cmd_d.mag[i] = cmd_d.neg[i] ? ({1'b0, ~thrust_i[i]} + MagW'(1))
                                  : {1'b0, thrust_i[i]};
    end
  end

  // Each half of the lanes reduces to one value, then the halves meet.
  always_comb begin
    pair_d[0] = mag_max(mag_max(cmd_q.mag[0], cmd_q.mag[1]),
                        mag_max(cmd_q.mag[2], cmd_q.mag[3]));
    pair_d[1] = mag_max(mag_max(cmd_q.mag[4], cmd_q.mag[5]),
                        mag_max(cmd_q.mag[6], cmd_q.mag[7]));
    peak_d    = mag_max(pair_q[0], pair_q[1]);
    ovf_d     = peak_d > MagW'(limit_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_q  <= cmd_d;
      pair_q <= pair_d;
      peak_q <= peak_d;
      ovf_q  <= ovf_d;
    end
  end

  assign cmd_o  = cmd_q;
  assign peak_o = peak_q;
  assign ovf_o  = ovf_q;

endmodule

### sv/tos_div_step.sv
// One registered restoring step of the limit-over-peak scale divider.
module tos_div_step import tos_pkg::*; #(
  parameter int unsigned FracW = FractionBitsDefault
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  mag_t             rem_i,
  input  mag_t             peak_i,
  input  logic [FracW-1:0] quo_i,
  output mag_t             rem_o,
  output mag_t             peak_o,
  output logic [FracW-1:0] quo_o
);

  logic [MagW:0]    dbl, diff;
  logic             ge;
  mag_t             rem_d, rem_q, peak_q;
  logic [FracW-1:0] quo_d, quo_q;

  // The dividend only brings down zeros below the limit, so each step doubles.
  always_comb begin
    dbl   = {rem_i, 1'b0};
    diff  = dbl - {1'b0, peak_i};
    ge    = dbl >= {1'b0, peak_i};
    rem_d = ge ? diff[MagW-1:0] : dbl[MagW-1:0];
    quo_d = {quo_i[FracW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      peak_q <= peak_i;
      quo_q  <= quo_d;
    end
  end

  assign rem_o  = rem_q;
  assign peak_o = peak_q;
  assign quo_o  = quo_q;

endmodule

### sv/tos_lane.sv
// One lane: magnitude times scale if ovf_i, then truncation and sign restore.
module tos_lane import tos_pkg::*; #(
  parameter int unsigned FracW = FractionBitsDefault
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  mag_t             mag_i,
  input  logic             neg_i,
  input  logic [FracW-1:0] scale_i,
  input  logic             ovf_i,
  output thrust_t          res_o
);

  localparam int unsigned ProdW = MagW + FracW;

  logic [ProdW-1:0] prod_d, prod_q;
  mag_t             mag_q, shifted, m;
  logic             neg_q;
  thrust_t          res_d, res_q;

  assign prod_d = ProdW'(mag_i) * ProdW'(scale_i);

  // ovf_i belongs to the set now held in prod_q.
  always_comb begin
    shifted = MagW'(prod_q >> FracW);
    m       = ovf_i ? shifted : mag_q;
    res_d   = neg_q ? (~m[ThrustW-1:0] + ThrustW'(1)) : m[ThrustW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      mag_q  <= mag_i;
      neg_q  <= neg_i;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### sv/thrust_overflow_scaler_core.sv
// Top level of the thrust overflow scaler: pipeline, lanes and output buffer.
// Takes one set of eight signed 16-bit thruster commands per clock while the input is ready
// and returns them unchanged when the largest magnitude is within thrust_limit; otherwise
// every command is multiplied by floor(limit * 2^FRACTION_BITS / peak) / 2^FRACTION_BITS
// and truncated toward zero, with tuser flagging the scaled case. The pipeline is the scale
// divider, which resolves one quotient bit per pipeline stage, plus the magnitude stage, two
// max-tree stages, the lane multiplier and the sign-restore stage.
// A two-entry output buffer keeps the input ready while a result waits; a stalled output
// stops the whole pipeline only once both entries are full. thrust_limit resets to 32767
// and must only be written while no request is in flight.
module thrust_overflow_scaler_core import tos_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FractionBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [LimitW-1:0]           cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // thrust_0 .. thrust_7, 16 bits each, thrust_0 in the lowest bits
  input  logic [NumLanes*ThrustW-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // scaled_0 .. scaled_7, 16 bits each, scaled_0 in the lowest bits
  output logic [NumLanes*ThrustW-1:0] m_axis_tdata,
  // overflow
  output logic                        m_axis_tuser
);

  localparam int unsigned DivFirst  = 3;
  localparam int unsigned ProdStage = FRACTION_BITS + DivFirst;
  localparam int unsigned NumStages = ProdStage + 2;
  localparam int unsigned ResStage  = NumStages - 1;

  typedef struct packed {
    logic                     ovf;
    thrust_t [NumLanes-1:0]   scaled;
  } res_t;

  logic [LimitW-1:0]    limit_q;
  logic                 en;
  logic [NumStages-1:0] valid_q;

  thrust_t [NumLanes-1:0] thrust;
  cmd_t                   cmd0;
  cmd_t                   cmd_q [ProdStage-1:1];
  mag_t                   peak2;
  logic                   ovf2;
  logic [ResStage:DivFirst] ovf_q;

  mag_t                     rem_s  [0:FRACTION_BITS];
  mag_t                     peak_s [0:FRACTION_BITS];
  logic [FRACTION_BITS-1:0] quo_s  [0:FRACTION_BITS];

  thrust_t [NumLanes-1:0] res;
  res_t                   pipe_data, out_d, out_q, skid_d, skid_q;
  logic                   push, pop;
  logic                   out_vld_d, out_vld_q, skid_vld_d, skid_vld_q;
  logic [NumLanes-1:0]    min_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // The whole pipeline moves together; it stops only when the skid entry is occupied.
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      thrust[i] = s_axis_tdata[i*ThrustW +: ThrustW];
    end
  end

  tos_peak u_peak (
    .clk_i   (clk_i),
    .en_i    (en),
    .thrust_i(thrust),
    .limit_i (limit_q),
    .cmd_o   (cmd0),
    .peak_o  (peak2),
    .ovf_o   (ovf2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_q[1] <= cmd0;
      for (int k = 2; k < ProdStage; k++) begin
        cmd_q[k] <= cmd_q[k-1];
      end
      ovf_q[DivFirst] <= ovf2;
      for (int k = DivFirst + 1; k <= ResStage; k++) begin
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // The remainder starts at the limit, which is below the peak whenever scaling applies.
  assign rem_s[0]  = MagW'(limit_q);
  assign peak_s[0] = peak2;
  assign quo_s[0]  = '0;

  for (genvar j = 0; j < FRACTION_BITS; j++) begin : g_div
    tos_div_step #(
      .FracW(FRACTION_BITS)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem_s[j]),
      .peak_i(peak_s[j]),
      .quo_i (quo_s[j]),
      .rem_o (rem_s[j+1]),
      .peak_o(peak_s[j+1]),
      .quo_o (quo_s[j+1])
    );
  end

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    tos_lane #(
      .FracW(FRACTION_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (cmd_q[ProdStage-1].mag[i]),
      .neg_i  (cmd_q[ProdStage-1].neg[i]),
      .scale_i(quo_s[FRACTION_BITS]),
      .ovf_i  (ovf_q[ProdStage]),
      .res_o  (res[i])
    );
  end

  assign pipe_data.scaled = res;
  assign pipe_data.ovf    = ovf_q[ResStage];
  assign push             = en && valid_q[ResStage];
  assign pop              = out_vld_q && m_axis_tready;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = push;
        out_d     = pipe_data;
      end
    end else if (push) begin
      skid_vld_d = 1'b1;
      skid_d     = pipe_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q.scaled;
  assign m_axis_tuser  = out_q.ovf;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      min_hit[i] = m_axis_tdata[i*ThrustW +: ThrustW] == {1'b1, {(ThrustW-1){1'b0}}};
    end
  end

  // A scale below one can never produce the most negative code.
  a_scaled_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> min_hit == '0)
    else $error("scaled result holds the most negative code");

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry occupied while the output register is empty");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ProdStage-1] && ovf_q[ProdStage-1] |->
      rem_s[FRACTION_BITS] < peak_s[FRACTION_BITS])
    else $error("divider remainder not below the peak");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a blocked output");

endmodule
